// ----- src/hbrp_pkg.sv -----
`timescale 1ns / 1ps

package hbrp_pkg;

    // Width of the accumulated decimal numbers.
    localparam int NUM_W = 63;

    // Parse phases; 0 to 5 are positions inside the "bytes=" prefix.
    localparam logic [3:0] PREFIX_LEN  = 4'd6;
    localparam logic [3:0] PH_AFTER_EQ = 4'd6;
    localparam logic [3:0] PH_START    = 4'd7;
    localparam logic [3:0] PH_END      = 4'd8;
    localparam logic [3:0] PH_SUF_DASH = 4'd9;
    localparam logic [3:0] PH_SUF      = 4'd10;
    localparam logic [3:0] PH_LF_RANGE = 4'd11;
    localparam logic [3:0] PH_LF_SUF   = 4'd12;

    // ASCII codes used by the parser.
    localparam logic [7:0] CH_DASH = 8'h2d;
    localparam logic [7:0] CH_LF   = 8'h0a;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    // Running parse state of one header.
    typedef struct packed {
        logic [3:0]       phase;
        logic [NUM_W-1:0] first_num;
        logic [NUM_W-1:0] second_num;
        logic             second_has_digits;
        logic             overflow;
        logic             syntax_error;
    } parse_state_t;

    // Expected byte at each prefix position.
    function automatic logic [7:0] prefix_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h62;
            3'd1:    c = 8'h79;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h65;
            3'd4:    c = 8'h73;
            3'd5:    c = 8'h3d;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- src/hbrp_if.sv -----
`timescale 1ns / 1ps

// Header byte channel.
interface hbrp_hdr_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       has_char;
    logic       last;

    modport source (output valid, ch, has_char, last, input ready);
    modport sink   (input valid, ch, has_char, last, output ready);
endinterface

// Parsed range channel.
interface hbrp_rng_if;
    logic               valid;
    logic               ready;
    logic               ok;
    logic               is_suffix;
    logic        [62:0] range_start;
    logic signed [63:0] range_end;
    logic        [62:0] suffix_len;

    modport source (output valid, ok, is_suffix, range_start, range_end, suffix_len,
                    input ready);
    modport sink   (input valid, ok, is_suffix, range_start, range_end, suffix_len,
                    output ready);
endinterface

// ----- src/hbrp_step.sv -----
`timescale 1ns / 1ps

module hbrp_step
    import hbrp_pkg::*;
(
    input  parse_state_t cur,
    input  logic [7:0]   ch,
    input  logic         has_char,
    output parse_state_t nxt
);

    logic             is_digit;
    logic [3:0]       digit;
    logic [NUM_W-1:0] acc;
    logic [NUM_W+3:0] sum;
    logic             digit_over;
    logic [NUM_W-1:0] digit_val;

    // Decode the byte; the low nibble of an ASCII digit is its value.
    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign digit    = ch[3:0];

    // One shared multiply-by-ten and add, on whichever number is being built.
    assign acc = (cur.phase == PH_END) ? cur.second_num : cur.first_num;
    assign sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{NUM_W{1'b0}}, digit};
    assign digit_over = |sum[NUM_W+3:NUM_W];
    assign digit_val  = digit_over ? acc : sum[NUM_W-1:0];

    // Phase transitions for one byte.
    always_comb
    begin
        nxt = cur;
        if (has_char && !cur.syntax_error)
        begin
            if (cur.phase < PREFIX_LEN)
            begin
                if (ch == prefix_char(cur.phase[2:0]))
                    nxt.phase = cur.phase + 4'd1;
                else
                    nxt.syntax_error = 1'b1;
            end
            else
            begin
                case (cur.phase)
                    PH_AFTER_EQ:
                    begin
                        if (is_digit)
                        begin
                            nxt.first_num = digit_val;
                            nxt.overflow  = cur.overflow | digit_over;
                            nxt.phase     = PH_START;
                        end
                        else if (ch == CH_DASH)
                            nxt.phase = PH_SUF_DASH;
                        else
                            nxt.syntax_error = 1'b1;
                    end
                    PH_START:
                    begin
                        if (is_digit)
                        begin
                            nxt.first_num = digit_val;
                            nxt.overflow  = cur.overflow | digit_over;
                        end
                        else if (ch == CH_DASH)
                            nxt.phase = PH_END;
                        else
                            nxt.syntax_error = 1'b1;
                    end
                    PH_END:
                    begin
                        if (is_digit)
                        begin
                            nxt.second_num        = digit_val;
                            nxt.second_has_digits = 1'b1;
                            nxt.overflow          = cur.overflow | digit_over;
                        end
                        else if (ch == CH_LF)
                            nxt.phase = PH_LF_RANGE;
                        else
                            nxt.syntax_error = 1'b1;
                    end
                    PH_SUF_DASH:
                    begin
                        if (is_digit)
                        begin
                            nxt.first_num = digit_val;
                            nxt.overflow  = cur.overflow | digit_over;
                            nxt.phase     = PH_SUF;
                        end
                        else
                            nxt.syntax_error = 1'b1;
                    end
                    PH_SUF:
                    begin
                        if (is_digit)
                        begin
                            nxt.first_num = digit_val;
                            nxt.overflow  = cur.overflow | digit_over;
                        end
                        else if (ch == CH_LF)
                            nxt.phase = PH_LF_SUF;
                        else
                            nxt.syntax_error = 1'b1;
                    end
                    default:
                        nxt.syntax_error = 1'b1;
                endcase
            end
        end
    end

endmodule

// ----- src/http_byte_range_parser.sv -----
// An accepted byte is registered, then steps the parse state; stalls can hold each stage.
// One header byte per cycle when not stalled; the byte step uses one 67-bit add.
// The final state goes to a snapshot register, the verdict compare to the output register.
// Reset is asynchronous and active low; it clears the parse state and all valid flags.
`timescale 1ns / 1ps

module http_byte_range_parser
    import hbrp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    hbrp_hdr_if.sink    hdr,
    hbrp_rng_if.source  result
);

    logic               s1_valid_reg;
    logic [7:0]         s1_ch_reg;
    logic               s1_has_char_reg;
    logic               s1_last_reg;
    parse_state_t       state_reg;
    parse_state_t       step_next;
    logic               snap_valid_reg;
    parse_state_t       snap_reg;
    logic               res_valid_reg;
    logic               res_ok_reg;
    logic               res_is_suffix_reg;
    logic [62:0]        res_start_reg;
    logic signed [63:0] res_end_reg;
    logic [62:0]        res_suffix_reg;

    logic               s1_adv;
    logic               snap_adv;
    logic               snap_free;
    logic               v_ok;
    logic               v_is_suffix;
    logic [62:0]        v_start;
    logic signed [63:0] v_end;
    logic [62:0]        v_suffix;

    // Pipeline flow control.
    assign snap_adv  = snap_valid_reg && (!res_valid_reg || result.ready);
    assign snap_free = !snap_valid_reg || snap_adv;
    assign s1_adv    = s1_valid_reg && (!s1_last_reg || snap_free);
    assign hdr.ready = !s1_valid_reg || s1_adv;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (hdr.ready)
            s1_valid_reg <= hdr.valid;
    end

    always_ff @(posedge clk)
    begin
        if (hdr.ready && hdr.valid)
        begin
            s1_ch_reg       <= hdr.ch;
            s1_has_char_reg <= hdr.has_char;
            s1_last_reg     <= hdr.last;
        end
    end

    // Byte step.
    hbrp_step u_step (
        .cur      (state_reg),
        .ch       (s1_ch_reg),
        .has_char (s1_has_char_reg),
        .nxt      (step_next)
    );

    // Parse state; it returns to reset after each last byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (s1_adv)
            state_reg <= s1_last_reg ? '0 : step_next;
    end

    // Snapshot of the final state of a header.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            snap_valid_reg <= 1'b0;
        else if (s1_adv && s1_last_reg)
            snap_valid_reg <= 1'b1;
        else if (snap_adv)
            snap_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_last_reg)
            snap_reg <= step_next;
    end

    // Verdict on a finished header; an invalid header gives all zeros.
    always_comb
    begin
        v_ok        = 1'b0;
        v_is_suffix = 1'b0;
        v_start     = '0;
        v_end       = '0;
        v_suffix    = '0;
        if (!snap_reg.syntax_error && !snap_reg.overflow)
        begin
            if (snap_reg.phase == PH_END || snap_reg.phase == PH_LF_RANGE)
            begin
                if (!snap_reg.second_has_digits)
                begin
                    v_ok    = 1'b1;
                    v_start = snap_reg.first_num;
                    v_end   = '1;
                end
                else if (snap_reg.second_num >= snap_reg.first_num)
                begin
                    v_ok    = 1'b1;
                    v_start = snap_reg.first_num;
                    v_end   = {1'b0, snap_reg.second_num};
                end
            end
            else if (snap_reg.phase == PH_SUF || snap_reg.phase == PH_LF_SUF)
            begin
                if (snap_reg.first_num != '0)
                begin
                    v_ok        = 1'b1;
                    v_is_suffix = 1'b1;
                    v_suffix    = snap_reg.first_num;
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (snap_adv)
            res_valid_reg <= 1'b1;
        else if (result.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (snap_adv)
        begin
            res_ok_reg        <= v_ok;
            res_is_suffix_reg <= v_is_suffix;
            res_start_reg     <= v_start;
            res_end_reg       <= v_end;
            res_suffix_reg    <= v_suffix;
        end
    end

    assign result.valid       = res_valid_reg;
    assign result.ok          = res_ok_reg;
    assign result.is_suffix   = res_is_suffix_reg;
    assign result.range_start = res_start_reg;
    assign result.range_end   = res_end_reg;
    assign result.suffix_len  = res_suffix_reg;

    // A header that has ended leaves the parser in its reset state.
    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && s1_last_reg |=> state_reg == '0)
        else $error("parse state not cleared after a last byte");

    // A waiting snapshot is neither lost nor overwritten.
    a_snap_held: assert property (@(posedge clk) disable iff (!rst_n)
        snap_valid_reg && !snap_adv |=> snap_valid_reg && $stable(snap_reg))
        else $error("pending snapshot changed");

    // An invalid result carries all-zero fields.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_ok_reg |-> !res_is_suffix_reg && res_start_reg == '0
            && res_end_reg == '0 && res_suffix_reg == '0)
        else $error("invalid result with non-zero fields");

    // A valid suffix result has a non-zero length and no start or end.
    a_suffix_form: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_is_suffix_reg |-> res_ok_reg && res_suffix_reg != '0
            && res_start_reg == '0 && res_end_reg == '0)
        else $error("malformed suffix result");

    // A valid start-end result is open or has END not below START.
    a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_ok_reg && !res_is_suffix_reg
            |-> res_end_reg == -64'sd1 || res_end_reg >= $signed({1'b0, res_start_reg}))
        else $error("range end below range start");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    import hbrp_pkg::*;

    localparam int N_ITEMS    = 950;
    localparam int QUIET_TAIL = 150;
    localparam int HOLD_AT    = 400;
    localparam int LONG_HOLD  = 200;
    localparam int STALL_MAX  = 2000;
    localparam int TAIL_WAIT  = 10;

    localparam logic [63:0] MAX63      = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [7:0]  HDR_PREFIX [0:5] = '{"b", "y", "t", "e", "s", "="};

    // One parsed range, laid out as the result channel carries it.
    typedef struct packed {
        logic               ok;
        logic               is_suffix;
        logic        [62:0] range_start;
        logic signed [63:0] range_end;
        logic        [62:0] suffix_len;
    } range_t;

    localparam range_t BAD_RANGE = '0;

    // One row of the directed table: header text and, where obvious, its verdict.
    typedef struct {
        string  txt;
        bit     typed;
        range_t want;
    } hdr_case_t;

    logic clk;
    logic rst_n;

    hbrp_hdr_if hdr ();
    hbrp_rng_if result ();

    http_byte_range_parser u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .hdr    (hdr),
        .result (result)
    );

    // Ranges still owed by the block, oldest first.
    range_t     expected_ranges[$];
    logic [7:0] hdr_bytes[$];

    int n_err      = 0;
    int items_sent = 0;
    int idle_cycles = 0;
    int tx_rate    = 20;
    int rx_rate    = 20;
    bit quiet      = 1'b0;
    bit hold_req   = 1'b0;
    bit hold_done  = 1'b0;

    // Shadow parse state of the header under way.
    logic [3:0]  pr_phase;
    logic [62:0] pr_first;
    logic [62:0] pr_second;
    logic        pr_second_seen;
    logic        pr_ovf;
    logic        pr_bad;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void clear_parse();
        pr_phase       = '0;
        pr_first       = '0;
        pr_second      = '0;
        pr_second_seen = 1'b0;
        pr_ovf         = 1'b0;
        pr_bad         = 1'b0;
    endfunction

    function automatic bit is_dec(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // Decimal accumulate; the value freezes once it would pass 2^63-1.
    function automatic logic [62:0] accum_digit(input logic [62:0] acc, input logic [7:0] c);
        logic [63:0] d;
        logic [63:0] wide;
        d = 64'(c - CH_ZERO);
        if ({1'b0, acc} > (MAX63 - d) / 64'd10)
        begin
            pr_ovf = 1'b1;
            return acc;
        end
        wide = {1'b0, acc} * 64'd10 + d;
        return wide[62:0];
    endfunction

    // Advance the shadow parse by one header byte.
    function automatic void feed_range_byte(input logic [7:0] c);
        if (pr_bad)
            return;
        if (pr_phase < PREFIX_LEN)
        begin
            if (c == HDR_PREFIX[pr_phase[2:0]])
                pr_phase = pr_phase + 4'd1;
            else
                pr_bad = 1'b1;
            return;
        end
        case (pr_phase)
            PH_AFTER_EQ:
            begin
                if (is_dec(c))
                begin
                    pr_first = accum_digit(pr_first, c);
                    pr_phase = PH_START;
                end
                else if (c == CH_DASH)
                    pr_phase = PH_SUF_DASH;
                else
                    pr_bad = 1'b1;
            end
            PH_START:
            begin
                if (is_dec(c))
                    pr_first = accum_digit(pr_first, c);
                else if (c == CH_DASH)
                    pr_phase = PH_END;
                else
                    pr_bad = 1'b1;
            end
            PH_END:
            begin
                if (is_dec(c))
                begin
                    pr_second      = accum_digit(pr_second, c);
                    pr_second_seen = 1'b1;
                end
                else if (c == CH_LF)
                    pr_phase = PH_LF_RANGE;
                else
                    pr_bad = 1'b1;
            end
            PH_SUF_DASH:
            begin
                if (is_dec(c))
                begin
                    pr_first = accum_digit(pr_first, c);
                    pr_phase = PH_SUF;
                end
                else
                    pr_bad = 1'b1;
            end
            PH_SUF:
            begin
                if (is_dec(c))
                    pr_first = accum_digit(pr_first, c);
                else if (c == CH_LF)
                    pr_phase = PH_LF_SUF;
                else
                    pr_bad = 1'b1;
            end
            default: pr_bad = 1'b1;
        endcase
    endfunction

    // Verdict on the header so far; the shadow state starts afresh afterwards.
    function automatic range_t close_range_header();
        range_t r;
        r = BAD_RANGE;
        if (!pr_bad && !pr_ovf)
        begin
            if (pr_phase == PH_END || pr_phase == PH_LF_RANGE)
            begin
                if (!pr_second_seen)
                begin
                    r.ok          = 1'b1;
                    r.range_start = pr_first;
                    r.range_end   = -64'sd1;
                end
                else if (pr_second >= pr_first)
                begin
                    r.ok          = 1'b1;
                    r.range_start = pr_first;
                    r.range_end   = {1'b0, pr_second};
                end
            end
            else if ((pr_phase == PH_SUF || pr_phase == PH_LF_SUF) && pr_first != '0)
            begin
                r.ok         = 1'b1;
                r.is_suffix  = 1'b1;
                r.suffix_len = pr_first;
            end
        end
        clear_parse();
        return r;
    endfunction

    function automatic range_t verdict(input logic ok, input logic sfx,
                                       input logic [62:0] st, input logic signed [63:0] en,
                                       input logic [62:0] len);
        range_t r;
        r.ok          = ok;
        r.is_suffix   = sfx;
        r.range_start = st;
        r.range_end   = en;
        r.suffix_len  = len;
        return r;
    endfunction

    function automatic hdr_case_t case_row(input string txt, input bit typed = 1'b0,
                                           input range_t want = '0);
        hdr_case_t row;
        row.txt   = txt;
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    function automatic int pick_rate();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 10;
            2:       return 30;
            default: return 60;
        endcase
    endfunction

    // Decimal text for one number: small, huge, at the limit, past it, zero-padded.
    function automatic string num_text();
        string       s;
        logic [62:0] v;
        case ($urandom_range(0, 9))
            0: s = "0";
            1: s = "9223372036854775807";
            2: s = "9223372036854775808";
            3:
            begin
                s = "";
                repeat ($urandom_range(1, 20))
                    s = $sformatf("%s%0d", s, $urandom_range(0, 9));
            end
            4: s = $sformatf("00%0d", $urandom_range(0, 99));
            5:
            begin
                v = 63'({$urandom(), $urandom()});
                s = $sformatf("%0d", v);
            end
            default: s = $sformatf("%0d", $urandom_range(0, 99999));
        endcase
        return s;
    endfunction

    // Offer one request and wait for it to be taken, then update the shadow parse.
    task automatic send_item(input logic [7:0] c, input logic has, input logic lst,
                             input bit typed, input range_t want);
        range_t pred;
        if (!quiet && $urandom_range(0, 99) < tx_rate)
        begin
            hdr.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        hdr.valid    <= 1'b1;
        hdr.ch       <= c;
        hdr.has_char <= has;
        hdr.last     <= lst;
        do
            @(posedge clk);
        while (!hdr.ready);

        if (has)
            feed_range_byte(c);
        if (lst)
        begin
            pred = close_range_header();
            expected_ranges.push_back(typed ? want : pred);
        end
        if (has || lst)
            items_sent++;
        quiet = items_sent >= N_ITEMS - QUIET_TAIL;
        if (!hold_done && items_sent >= HOLD_AT)
        begin
            hold_req  = 1'b1;
            hold_done = 1'b1;
        end
        if ($urandom_range(0, 39) == 0)
            tx_rate = pick_rate();
    endtask

    // Send the bytes in hdr_bytes as one header; holes adds byte-less requests.
    task automatic send_header(input bit typed, input range_t want, input bit holes);
        int n;
        bit tail_empty;
        n          = hdr_bytes.size();
        tail_empty = (n == 0) || (holes && $urandom_range(0, 9) == 0);
        for (int i = 0; i < n; i++)
        begin
            if (holes && $urandom_range(0, 15) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, want);
            send_item(hdr_bytes[i], 1'b1, !tail_empty && i == n - 1, typed, want);
        end
        if (tail_empty)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, typed, want);
    endtask

    // Mostly well-formed headers with random numbers; some damaged, some pure noise.
    task automatic build_random_header();
        string s;
        int    kind;
        int    pos;
        kind = $urandom_range(0, 19);
        if ($urandom_range(0, 1) == 0)
        begin
            s = {"bytes=", num_text(), "-"};
            if ($urandom_range(0, 3) != 0)
                s = {s, num_text()};
        end
        else
            s = {"bytes=-", num_text()};
        if ($urandom_range(0, 3) == 0)
            s = {s, "\n"};

        hdr_bytes.delete();
        if (kind >= 18)
        begin
            repeat ($urandom_range(0, 10))
                hdr_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            for (int i = 0; i < s.len(); i++)
                hdr_bytes.push_back(s[i]);
            if (kind >= 14)
            begin
                pos = $urandom_range(0, hdr_bytes.size() - 1);
                case ($urandom_range(0, 3))
                    0: hdr_bytes[pos] = 8'($urandom_range(0, 255));
                    1:
                    begin
                        while (hdr_bytes.size() > pos)
                            void'(hdr_bytes.pop_back());
                    end
                    2: hdr_bytes.insert(pos, 8'($urandom_range(0, 255)));
                    default:
                    begin
                        hdr_bytes.push_back(CH_LF);
                        hdr_bytes.push_back(($urandom_range(0, 1) == 0) ? CH_LF
                                            : 8'($urandom_range(0, 255)));
                    end
                endcase
            end
        end
    endtask

    // Stop offering and let every owed range come out.
    task automatic drain_ranges();
        hdr.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_ranges.size() != 0);
    endtask

    // Sender: reset, directed table, random headers, final wait.
    initial
    begin : header_source
        hdr_case_t dir_rows[$];
        bit        drained;
        drained = 1'b0;
        clear_parse();
        rst_n        <= 1'b0;
        hdr.valid    <= 1'b0;
        hdr.ch       <= '0;
        hdr.has_char <= 1'b0;
        hdr.last     <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir_rows = '{
            case_row("", 1'b1, BAD_RANGE),
            case_row("bytes=0-", 1'b1, verdict(1'b1, 1'b0, '0, -64'sd1, '0)),
            case_row("bytes=0-0", 1'b1, verdict(1'b1, 1'b0, '0, 64'sd0, '0)),
            case_row("bytes=9223372036854775807-", 1'b1,
                     verdict(1'b1, 1'b0, MAX63[62:0], -64'sd1, '0)),
            case_row("bytes=0-9223372036854775807", 1'b1,
                     verdict(1'b1, 1'b0, '0, $signed(MAX63), '0)),
            case_row("bytes=9223372036854775808-", 1'b1, BAD_RANGE),
            case_row("bytes=-9223372036854775807", 1'b1,
                     verdict(1'b1, 1'b1, '0, 64'sd0, MAX63[62:0])),
            case_row("bytes=-0", 1'b1, BAD_RANGE),
            case_row("bytes=-1\n", 1'b1, verdict(1'b1, 1'b1, '0, 64'sd0, 63'd1)),
            case_row("bytes=5-3", 1'b1, BAD_RANGE),
            case_row("bytes=10-20\n\n", 1'b1, BAD_RANGE),
            case_row("Bytes=0-1", 1'b1, BAD_RANGE),
            case_row("bytes=", 1'b1, BAD_RANGE),
            case_row("bytes=12", 1'b1, BAD_RANGE),
            case_row("bytes=-", 1'b1, BAD_RANGE),
            case_row("bytes=1-2,3-4", 1'b1, BAD_RANGE),
            case_row("\377", 1'b1, BAD_RANGE),
            case_row("bytes=007-010\n"),
            case_row("bytes=100-200"),
            case_row("bytes=-42"),
            case_row("bytes=3-\n")
        };

        foreach (dir_rows[r])
        begin
            hdr_bytes.delete();
            for (int i = 0; i < dir_rows[r].txt.len(); i++)
                hdr_bytes.push_back(dir_rows[r].txt[i]);
            send_header(dir_rows[r].typed, dir_rows[r].want, 1'b0);
        end
        drain_ranges();

        while (items_sent < N_ITEMS)
        begin
            build_random_header();
            send_header(1'b0, BAD_RANGE, 1'b1);
            if (!drained && items_sent >= (N_ITEMS * 2) / 3)
            begin
                drain_ranges();
                drained = 1'b1;
            end
        end

        drain_ranges();
        repeat (TAIL_WAIT) @(posedge clk);
        if (n_err == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Receiver: random stalls, one long hold-off, steady in the last stretch.
    initial
    begin : range_sink
        result.ready <= 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                result.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 99) < rx_rate)
            begin
                result.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            else
            begin
                result.ready <= 1'b1;
                @(posedge clk);
            end
            if ($urandom_range(0, 39) == 0)
                rx_rate = pick_rate();
        end
    end

    // Compare each delivered range with the oldest one owed.
    always @(posedge clk)
    begin : range_check
        range_t want;
        if (result.valid === 1'b1 && result.ready === 1'b1)
        begin
            if (expected_ranges.size() == 0)
            begin
                $error("range result delivered with no request pending");
                n_err++;
            end
            else
            begin
                want = expected_ranges.pop_front();
                if (result.ok !== want.ok)
                begin
                    $error("ok: expected %0d, got %0d", want.ok, result.ok);
                    n_err++;
                end
                if (result.is_suffix !== want.is_suffix)
                begin
                    $error("is_suffix: expected %0d, got %0d", want.is_suffix, result.is_suffix);
                    n_err++;
                end
                if (result.range_start !== want.range_start)
                begin
                    $error("range_start: expected %0d, got %0d",
                           want.range_start, result.range_start);
                    n_err++;
                end
                if (result.range_end !== want.range_end)
                begin
                    $error("range_end: expected %0d, got %0d", want.range_end, result.range_end);
                    n_err++;
                end
                if (result.suffix_len !== want.suffix_len)
                begin
                    $error("suffix_len: expected %0d, got %0d",
                           want.suffix_len, result.suffix_len);
                    n_err++;
                end
            end
        end
    end

    // Watchdog: too long with no request moving on either channel ends the run.
    always @(posedge clk)
    begin : stall_watch
        if (!rst_n || (hdr.valid && hdr.ready) || (result.valid && result.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_MAX)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
